/* design/wac_pkg.sv */
// ----------------------------------------------------------------------------
// wac_pkg
// Shared widths, register codes and reset values for the curve clustering unit.
// ----------------------------------------------------------------------------
package wac_pkg;

  localparam int DEF_MAX_CURVES = 32;

  localparam int APEX_W     = 20;
  localparam int VAL_W      = 32;
  localparam int WGT_W      = 16;
  localparam int SCORE_W    = 21;
  localparam int THR_W      = 19;
  localparam int JF_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  localparam logic [THR_W-1:0] MERGE_THR_RST = 19'd80;
  localparam logic [JF_W-1:0]  JUMP_FACT_RST = 4'd3;
  localparam logic [THR_W-1:0] JUMP_MIN_RST  = 19'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MERGE_THR   = 2'd0,
    CFG_JUMP_FACTOR = 2'd1,
    CFG_JUMP_MIN    = 2'd2
  } cfg_idx_t;

  typedef logic signed [APEX_W-1:0] apex_t;
  typedef logic signed [VAL_W-1:0]  val_t;

endpackage

/* design/wac_in_if.sv */
// ----------------------------------------------------------------------------
// wac_in_if
// Curve input channel: valid/ready handshake with one curve per transaction.
// ----------------------------------------------------------------------------
interface wac_in_if import wac_pkg::*; ;
  logic               valid;
  logic               ready;
  apex_t              apex_y;
  val_t               curve_param;
  val_t               curve_angle;
  val_t               curve_origin;
  logic [WGT_W-1:0]   weight;
  logic               last_item;

  modport source (output valid, apex_y, curve_param, curve_angle, curve_origin,
                  weight, last_item, input ready);
  modport sink   (input valid, apex_y, curve_param, curve_angle, curve_origin,
                  weight, last_item, output ready);
endinterface

/* design/wac_out_if.sv */
// ----------------------------------------------------------------------------
// wac_out_if
// Cluster result channel: valid/ready handshake with one cluster per transaction.
// ----------------------------------------------------------------------------
interface wac_out_if import wac_pkg::*; ;
  logic               valid;
  logic               ready;
  apex_t              out_apex_y;
  val_t               out_param;
  val_t               out_angle;
  val_t               out_origin;
  logic [SCORE_W-1:0] out_score;
  logic               none_found;
  logic               last_result;

  modport source (output valid, out_apex_y, out_param, out_angle, out_origin,
                  out_score, none_found, last_result, input ready);
  modport sink   (input valid, out_apex_y, out_param, out_angle, out_origin,
                  out_score, none_found, last_result, output ready);
endinterface

/* design/weighted_agglomerative_clustering_unit.sv */
// ----------------------------------------------------------------------------
// weighted_agglomerative_clustering_unit
// Loads a set of curves, merges them bottom up by apex distance, keeps the
// best clustering and streams it out one cluster per transaction.
//
//   channel   dir  transaction
//   curves    in   one curve; last_item starts the run
//   results   out  one cluster, or one none_found item
//   cfg       in   register write, no wait
//
// Loading accepts one curve per cycle. A merge round scans the candidate pairs,
// copies every stored curve slot to the snapshot store when it keeps a clustering
// and runs the centroid divide; each output cluster divides its sums in the
// shared divider. curves.ready is low for the whole run.
// Reset is synchronous; no store is cleared. results stalls hold the sequencer.
// ----------------------------------------------------------------------------
module weighted_agglomerative_clustering_unit import wac_pkg::*; #(
  parameter int MAX_CURVES = DEF_MAX_CURVES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wac_in_if.sink                curves,
  wac_out_if.source             results
);

  localparam int IW     = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
  localparam int CW     = $clog2(MAX_CURVES + 1);
  localparam int WW     = WGT_W + $clog2(MAX_CURVES);
  localparam int SUMW   = VAL_W + WGT_W + $clog2(MAX_CURVES);
  localparam int PROD_W = 2 * APEX_W;
  localparam int JP_W   = APEX_W + JF_W;

  typedef struct packed {
    logic signed [SUMW-1:0] sy;
    logic signed [SUMW-1:0] sp;
    logic signed [SUMW-1:0] sa;
    logic signed [SUMW-1:0] so;
    logic [WW-1:0]          w;
    apex_t                  cy;
  } ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SI, S_SLATCH, S_SJ, S_SCMP, S_EVAL, S_RATIO, S_SNAP_RD,
    S_SNAP_WR, S_MA, S_MB, S_MW, S_MDIV, S_OSTART, S_OSEEK, S_OLOAD,
    S_OD1, S_OD2, S_OD3, S_OWAIT
  } state_t;

  // configuration
  logic [THR_W-1:0] merge_thr;
  logic [JF_W-1:0]  jump_fact;
  logic [THR_W-1:0] jump_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_thr <= MERGE_THR_RST;
      jump_fact <= JUMP_FACT_RST;
      jump_min  <= JUMP_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MERGE_THR:   merge_thr <= cfg_wdata[THR_W-1:0];
        CFG_JUMP_FACTOR: jump_fact <= cfg_wdata[JF_W-1:0];
        CFG_JUMP_MIN:    jump_min  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         n;
  logic [MAX_CURVES-1:0] alive;
  logic [MAX_CURVES-1:0] snap_alive;
  logic [CW-1:0]         ci, cj, ck, ok;
  logic [IW-1:0]         bi, bj;
  apex_t                 yi;
  logic [APEX_W-1:0]     best;
  logic                  have;
  logic [APEX_W-1:0]     prev_d, prev_c, chg_r;
  logic [APEX_W-1:0]     bnum, bden;
  logic                  bvalid;
  logic                  taken;
  logic                  stop_run;
  logic [PROD_W-1:0]     prod_l, prod_r;
  ent_t                  ea, em, se;
  val_t                  qp, qa;
  logic                  olast_r;

  // result registers
  logic                  ov;
  apex_t                 oy;
  val_t                  op, oa, oo;
  logic [SCORE_W-1:0]    os;
  logic                  onone;

  // cluster and snapshot stores
  ent_t mem  [MAX_CURVES];
  ent_t smem [MAX_CURVES];
  ent_t rd, srd;
  logic [IW-1:0] raddr;
  logic          mwe;
  logic [IW-1:0] mwa;
  ent_t          mwd;

  // divider
  logic                   div_start;
  logic signed [SUMW-1:0] div_num;
  logic [WW-1:0]          div_den;
  logic                   div_done;
  logic [VAL_W-1:0]       div_q;

  // load path
  logic [WGT_W-1:0]               w16;
  logic signed [APEX_W+WGT_W:0]   py;
  logic signed [VAL_W+WGT_W:0]    pp, pa, po;
  ent_t                           new_ent;
  logic                           acc;
  logic                           room;
  logic [CW-1:0]                  count_new;

  // scan / decision
  logic signed [APEX_W:0] diff;
  logic [APEX_W-1:0]      gap;
  logic [APEX_W-1:0]      chg;
  logic [JP_W-1:0]        jp;
  logic                   over, stop, better;
  ent_t                   merged;
  logic                   olast;

  assign acc       = curves.valid && curves.ready;
  assign room      = count < CW'(MAX_CURVES);
  assign count_new = room ? count + CW'(1) : count;
  assign w16       = (curves.weight == '0) ? WGT_W'(1) : curves.weight;

  always_comb begin
    py = curves.apex_y * $signed({1'b0, w16});
    pp = curves.curve_param * $signed({1'b0, w16});
    pa = curves.curve_angle * $signed({1'b0, w16});
    po = curves.curve_origin * $signed({1'b0, w16});
    new_ent.sy = SUMW'(py);
    new_ent.sp = SUMW'(pp);
    new_ent.sa = SUMW'(pa);
    new_ent.so = SUMW'(po);
    new_ent.w  = WW'(w16);
    new_ent.cy = curves.apex_y;
  end

  always_comb begin
    merged    = ea;
    merged.sy = ea.sy + rd.sy;
    merged.sp = ea.sp + rd.sp;
    merged.sa = ea.sa + rd.sa;
    merged.so = ea.so + rd.so;
    merged.w  = ea.w + rd.w;
  end

  assign diff  = {yi[APEX_W-1], yi} - {rd.cy[APEX_W-1], rd.cy};
  assign gap   = diff[APEX_W] ? APEX_W'(-diff) : APEX_W'(diff);
  assign chg   = (best > prev_d) ? best - prev_d : prev_d - best;
  assign jp    = JP_W'(prev_c) * JP_W'(jump_fact);
  assign over  = best > {1'b0, merge_thr};
  assign stop  = (JP_W'(chg) > jp) && (chg > {1'b0, jump_min});
  assign better = !bvalid || ((bden != '0) && ((prev_d == '0) || (prod_l < prod_r)));

  always_comb begin
    olast = 1'b1;
    for (int k = 0; k < MAX_CURVES; k++) begin
      if ((CW'(k) > ok) && snap_alive[k]) begin
        olast = 1'b0;
      end
    end
  end

  always_comb begin
    case (state)
      S_SI:      raddr = ci[IW-1:0];
      S_SJ:      raddr = cj[IW-1:0];
      S_SNAP_RD: raddr = ck[IW-1:0];
      S_MB:      raddr = bj;
      default:   raddr = bi;
    endcase
  end

  always_comb begin
    mwe    = 1'b0;
    mwa    = bi;
    mwd    = em;
    mwd.cy = div_q[APEX_W-1:0];
    if (state == S_IDLE) begin
      mwe = acc && room;
      mwa = count[IW-1:0];
      mwd = new_ent;
    end else if (state == S_MDIV) begin
      mwe = div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[mwa] <= mwd;
    end
    rd <= mem[raddr];
    if (state == S_SNAP_WR) begin
      smem[ck[IW-1:0]] <= rd;
    end
    srd <= smem[ok[IW-1:0]];
  end

  always_comb begin
    div_start = (state == S_MW) || (state == S_OLOAD) ||
                (state == S_OD1 && div_done) || (state == S_OD2 && div_done);
    case (state)
      S_MW: begin
        div_num = merged.sy;
        div_den = merged.w;
      end
      S_OLOAD: begin
        div_num = srd.sp;
        div_den = srd.w;
      end
      S_OD1: begin
        div_num = se.sa;
        div_den = se.w;
      end
      default: begin
        div_num = se.so;
        div_den = se.w;
      end
    endcase
  end

  wac_div #(.SUM_W(SUMW), .DEN_W(WW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      alive    <= '0;
      ov       <= 1'b0;
      have     <= 1'b0;
      bvalid   <= 1'b0;
      taken    <= 1'b0;
      stop_run <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (room) begin
              alive[count[IW-1:0]] <= 1'b1;
            end
            count <= count_new;
            if (curves.last_item) begin
              n        <= count_new;
              prev_d   <= '0;
              prev_c   <= '0;
              bnum     <= '0;
              bden     <= '0;
              bvalid   <= 1'b0;
              taken    <= 1'b0;
              stop_run <= 1'b0;
              have     <= 1'b0;
              ci       <= '0;
              state    <= (count_new > CW'(1)) ? S_SI : S_OSTART;
            end
          end
        end
        S_SI: begin
          if (ci == count) begin
            state <= S_EVAL;
          end else if (alive[ci[IW-1:0]]) begin
            cj    <= ci + CW'(1);
            state <= S_SLATCH;
          end else begin
            ci <= ci + CW'(1);
          end
        end
        S_SLATCH: begin
          yi    <= rd.cy;
          state <= S_SJ;
        end
        S_SJ: begin
          if (cj == count) begin
            ci    <= ci + CW'(1);
            state <= S_SI;
          end else if (alive[cj[IW-1:0]]) begin
            state <= S_SCMP;
          end else begin
            cj <= cj + CW'(1);
          end
        end
        S_SCMP: begin
          if (!have || gap < best) begin
            have <= 1'b1;
            best <= gap;
            bi   <= ci[IW-1:0];
            bj   <= cj[IW-1:0];
          end
          cj    <= cj + CW'(1);
          state <= S_SJ;
        end
        S_EVAL: begin
          prod_l <= PROD_W'(bnum) * PROD_W'(prev_d);
          prod_r <= PROD_W'(best) * PROD_W'(bden);
          chg_r  <= chg;
          ck     <= '0;
          if (over && stop) begin
            stop_run <= 1'b1;
            state    <= S_SNAP_RD;
          end else if (over) begin
            state <= S_RATIO;
          end else begin
            state <= S_MA;
          end
        end
        S_RATIO: begin
          if (better) begin
            bnum   <= best;
            bden   <= prev_d;
            bvalid <= 1'b1;
            state  <= S_SNAP_RD;
          end else begin
            state <= S_MA;
          end
        end
        S_SNAP_RD: begin
          if (ck == count) begin
            snap_alive <= alive;
            taken      <= 1'b1;
            state      <= stop_run ? S_OSTART : S_MA;
          end else begin
            state <= S_SNAP_WR;
          end
        end
        S_SNAP_WR: begin
          ck    <= ck + CW'(1);
          state <= S_SNAP_RD;
        end
        S_MA: begin
          state <= S_MB;
        end
        S_MB: begin
          ea    <= rd;
          state <= S_MW;
        end
        S_MW: begin
          em        <= merged;
          alive[bj] <= 1'b0;
          state     <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            prev_d <= best;
            prev_c <= chg_r;
            n      <= n - CW'(1);
            ci     <= '0;
            have   <= 1'b0;
            state  <= (n - CW'(1) > CW'(1)) ? S_SI : S_OSTART;
          end
        end
        S_OSTART: begin
          ok <= '0;
          if (!taken) begin
            oy      <= '0;
            op      <= '0;
            oa      <= '0;
            oo      <= '0;
            os      <= '0;
            onone   <= 1'b1;
            olast_r <= 1'b1;
            ov      <= 1'b1;
            state   <= S_OWAIT;
          end else begin
            state <= S_OSEEK;
          end
        end
        S_OSEEK: begin
          if (snap_alive[ok[IW-1:0]]) begin
            state <= S_OLOAD;
          end else begin
            ok <= ok + CW'(1);
          end
        end
        S_OLOAD: begin
          se    <= srd;
          state <= S_OD1;
        end
        S_OD1: begin
          if (div_done) begin
            qp    <= div_q;
            state <= S_OD2;
          end
        end
        S_OD2: begin
          if (div_done) begin
            qa    <= div_q;
            state <= S_OD3;
          end
        end
        S_OD3: begin
          if (div_done) begin
            oy      <= se.cy;
            op      <= qp;
            oa      <= qa;
            oo      <= div_q;
            os      <= SCORE_W'(se.w);
            onone   <= 1'b0;
            olast_r <= olast;
            ov      <= 1'b1;
            state   <= S_OWAIT;
          end
        end
        S_OWAIT: begin
          if (results.ready) begin
            ov <= 1'b0;
            if (olast_r) begin
              count <= '0;
              alive <= '0;
              state <= S_IDLE;
            end else begin
              ok    <= ok + CW'(1);
              state <= S_OSEEK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign curves.ready        = (state == S_IDLE);
  assign results.valid       = ov;
  assign results.out_apex_y  = oy;
  assign results.out_param   = op;
  assign results.out_angle   = oa;
  assign results.out_origin  = oo;
  assign results.out_score   = os;
  assign results.none_found  = onone;
  assign results.last_result = olast_r;

endmodule

/* design/wac_div.sv */
// ----------------------------------------------------------------------------
// wac_div
// Restoring divider, one quotient bit per cycle: signed sum over weight,
// rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module wac_div import wac_pkg::*; #(
  parameter int SUM_W = 53,
  parameter int DEN_W = 21
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic        [VAL_W-1:0] quo
);

  localparam int DW    = SUM_W + 1;
  localparam int CNT_W = $clog2(DW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [DW-1:0]    qr;
  logic             neg;

  logic [DW-1:0]    ext;
  logic [DW-1:0]    mag;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign ext   = {num[SUM_W-1], num};
  assign mag   = num[SUM_W-1] ? (~ext + DW'(1)) : ext;
  assign trial = {rem, qr[DW-1]};
  assign ge    = trial >= {1'b0, dv};
  assign quo   = neg ? (~qr[VAL_W-1:0] + VAL_W'(1)) : qr[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dv   <= den;
        neg  <= num[SUM_W-1];
        qr   <= mag + DW'(den >> 1);
      end else if (busy) begin
        rem <= ge ? DEN_W'(trial - {1'b0, dv}) : DEN_W'(trial);
        qr  <= {qr[DW-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
